// ===== hw/rtl/sd_spi_response_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// SD SPI response receiver - assertion macros
// Shared concurrent assertion forms used by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_RESPONSE_RECEIVER_DEFINES_SVH
`define SD_SPI_RESPONSE_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// SD SPI response receiver - package
// Types, status codes, token bytes and register map.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_RETRY_LIMIT = 2'd0,
        REG_DATA_LENGTH = 2'd1,
        REG_BUSY_LIMIT  = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_OK      = 3'd1,
        ST_TIMEOUT = 3'd2,
        ST_TOKEN   = 3'd3,
        ST_BUSY    = 3'd4
    } t_status;

    localparam logic [7:0]  START_TOKEN       = 8'hFE;
    localparam logic [7:0]  IDLE_BYTE         = 8'hFF;
    localparam logic [15:0] RETRY_LIMIT_RESET = 16'd1000;
    localparam logic [10:0] DATA_LENGTH_RESET = 11'd0;
    localparam logic [7:0]  BUSY_LIMIT_RESET  = 8'd20;

    typedef struct packed {
        logic [15:0] retry_limit;
        logic [10:0] data_length;
        logic [7:0]  busy_limit;
    } t_cfg;

endpackage

// ===== hw/rtl/ssr_ifs.sv =====
// ----------------------------------------------------------------------------
// SD SPI response receiver - channel interfaces
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
interface ssr_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface ssr_rsp_if;
    import ssr_pkg::*;

    logic       valid;
    logic       ready;
    t_status    status;
    logic [7:0] r1_value;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       done_res;

    modport source (output valid, output status, output r1_value, output data_byte,
                    output data_valid, output done_res, input ready);
    modport sink (input valid, input status, input r1_value, input data_byte,
                  input data_valid, input done_res, output ready);
endinterface

// ===== hw/rtl/ssr_regs.sv =====
// ----------------------------------------------------------------------------
// SD SPI response receiver - configuration registers
// APB-style register file for retry, length and busy limits.
// ----------------------------------------------------------------------------
module ssr_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output ssr_pkg::t_cfg              o_cfg
);
    import ssr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit <= RETRY_LIMIT_RESET;
            r_cfg.data_length <= DATA_LENGTH_RESET;
            r_cfg.busy_limit  <= BUSY_LIMIT_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_RETRY_LIMIT: r_cfg.retry_limit <= pwdata[15:0];
                REG_DATA_LENGTH: r_cfg.data_length <= pwdata[10:0];
                REG_BUSY_LIMIT:  r_cfg.busy_limit  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RETRY_LIMIT: prdata = {16'd0, r_cfg.retry_limit};
            REG_DATA_LENGTH: prdata = {21'd0, r_cfg.data_length};
            REG_BUSY_LIMIT:  prdata = {24'd0, r_cfg.busy_limit};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/sd_spi_response_receiver.sv =====
// ----------------------------------------------------------------------------
// SD SPI response receiver
// Tracks R1, start token, payload and busy release of an SD card in SPI mode.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one item per SPI byte: cmd 0 arms a new response wait,
//   cmd 1 delivers rx_byte as read from the card. Every accepted item gives
//   exactly one result item on o_rsp: status, captured R1, payload byte with
//   its data_valid flag, and done_res when the status is final.
//   Limits are set through the APB port (retry_limit at 0x0, data_length at
//   0x4, busy_limit at 0x8) while no item is in flight.
//   An accepted item goes through an input register, then one pass of the
//   phase logic into the result register, from which o_rsp offers it. One
//   item per cycle is sustained while o_rsp keeps taking results; the phase
//   and counter registers update from the phase logic on each item.
//   When o_rsp stalls the result register holds and the input register
//   still takes one item; i_req.ready drops only when both are full.
//   Reset (synchronous, active low) returns the block to idle with counts
//   and captured R1 cleared and the limits at 1000, 0 and 20.
// ----------------------------------------------------------------------------
`include "sd_spi_response_receiver_defines.svh"

module sd_spi_response_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ssr_req_if.sink                    i_req,
    ssr_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ssr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_R1      = 3'd1,
        PH_TOKEN   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_BUSY    = 3'd4
    } t_phase;

    t_cfg        w_cfg;

    logic        r_in_valid;
    logic        r_cmd;
    logic [7:0]  r_byte;

    t_phase      r_phase,   n_phase;
    logic [16:0] r_attempt, n_attempt;
    logic [10:0] r_payload, n_payload;
    logic [7:0]  r_r1,      n_r1;

    logic        r_out_valid;
    t_status     r_status,  n_status;
    logic [7:0]  r_dbyte,   n_dbyte;
    logic        r_dvalid,  n_dvalid;
    logic        r_done,    n_done;

    logic        w_adv;
    logic        w_fire;
    logic        w_in_ready;
    logic [16:0] w_att_inc;
    logic [16:0] w_tries;
    logic [10:0] w_pay_inc;

    ssr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = !r_out_valid || o_rsp.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_req.ready = w_in_ready;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.r1_value   = r_r1;
    assign o_rsp.data_byte  = r_dbyte;
    assign o_rsp.data_valid = r_dvalid;
    assign o_rsp.done_res   = r_done;

    assign w_att_inc = r_attempt + 17'd1;
    assign w_tries   = {1'b0, w_cfg.retry_limit} + 17'd1;
    assign w_pay_inc = r_payload + 11'd1;

    always_comb begin
        n_phase   = r_phase;
        n_attempt = r_attempt;
        n_payload = r_payload;
        n_r1      = r_r1;
        n_status  = ST_RUN;
        n_dbyte   = 8'd0;
        n_dvalid  = 1'b0;
        n_done    = 1'b0;
        if (!r_cmd) begin
            n_phase   = PH_R1;
            n_attempt = 17'd0;
            n_payload = 11'd0;
            n_r1      = 8'd0;
        end else begin
            case (r_phase)
                PH_R1: begin
                    n_attempt = w_att_inc;
                    if (!r_byte[7]) begin
                        n_r1      = r_byte;
                        n_attempt = 17'd0;
                        n_phase   = (w_cfg.data_length == 11'd0) ? PH_BUSY : PH_TOKEN;
                    end else if (w_att_inc >= w_tries) begin
                        n_status = ST_TIMEOUT;
                        n_done   = 1'b1;
                    end
                end
                PH_TOKEN: begin
                    n_attempt = w_att_inc;
                    if (r_byte == START_TOKEN) begin
                        n_payload = 11'd0;
                        if (w_cfg.data_length <= 11'd1) begin
                            n_phase   = PH_BUSY;
                            n_attempt = 17'd0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else if (r_byte != IDLE_BYTE) begin
                        n_status = ST_TOKEN;
                        n_done   = 1'b1;
                    end else if (w_att_inc >= w_tries) begin
                        n_status = ST_TIMEOUT;
                        n_done   = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_dbyte   = r_byte;
                    n_dvalid  = 1'b1;
                    n_payload = w_pay_inc;
                    if (w_cfg.data_length <= 11'd1 ||
                        w_pay_inc >= w_cfg.data_length - 11'd1) begin
                        n_phase   = PH_BUSY;
                        n_attempt = 17'd0;
                    end
                end
                PH_BUSY: begin
                    n_attempt = w_att_inc;
                    if (r_byte == IDLE_BYTE) begin
                        n_status = ST_OK;
                        n_done   = 1'b1;
                    end else if (w_att_inc >= {9'd0, w_cfg.busy_limit}) begin
                        n_status = ST_BUSY;
                        n_done   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (n_done) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_attempt   <= 17'd0;
            r_payload   <= 11'd0;
            r_r1        <= 8'd0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_phase   <= n_phase;
                r_attempt <= n_attempt;
                r_payload <= n_payload;
                r_r1      <= n_r1;
            end
        end
        if (w_in_ready && i_req.valid) begin
            r_cmd  <= i_req.cmd;
            r_byte <= i_req.rx_byte;
        end
        if (w_fire) begin
            r_status <= n_status;
            r_dbyte  <= n_dbyte;
            r_dvalid <= n_dvalid;
            r_done   <= n_done;
        end
    end

    `SSR_ASSERT_NOW(a_payload_not_final, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.data_valid,
        o_rsp.status == ST_RUN && !o_rsp.done_res, "payload item carries a final status")

    `SSR_ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n,
        w_fire && n_done, r_phase == PH_IDLE, "final result without return to idle")

    `SSR_ASSERT_NEXT(a_in_stage_holds, i_clk, i_rst_n,
        r_in_valid && !w_adv, r_in_valid && $stable(r_byte) && $stable(r_cmd),
        "held item lost from input stage")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD SPI response receiver - testbench
// Feeds arm and received-byte items through the request channel, predicts
// every result item from a software copy of the receiver state and register
// settings, and checks the result channel field by field. A short directed
// set covers limits, tokens and the edge cases. Random well-formed response
// sequences with some noise follow, run over many register settings. The
// sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
    import ssr_pkg::*;

    localparam logic CMD_ARM     = 1'b0;
    localparam logic CMD_BYTE    = 1'b1;
    localparam int   LATENCY     = 2;
    localparam int   WDOG_LIMIT  = 2000;
    localparam int   ITEM_TARGET = 950;
    localparam int   MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        WAIT_IDLE,
        WAIT_R1,
        WAIT_TOKEN,
        WAIT_PAYLOAD,
        WAIT_BUSY
    } t_phase;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_spi_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] r1_value;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
    } t_rsp_item;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    ssr_req_if req_if();
    ssr_rsp_if rsp_if();

    sd_spi_response_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // receiver shadow: registers and state
    t_cfg        cfg;
    t_phase      rx_phase;
    logic [16:0] attempts;
    logic [10:0] payload_cnt;
    logic [7:0]  r1_held;

    t_spi_item   byte_q[$];
    t_rsp_item   rsp_due_q[$];

    int unsigned gen_count    = 0;
    int unsigned item_count   = 0;
    int unsigned rsp_count    = 0;
    int unsigned err_count    = 0;
    int unsigned idle_cycles  = 0;
    int unsigned phase_count  = 0;
    int unsigned payload_seen = 0;
    int unsigned status_seen[8];

    logic        running   = 1'b0;
    logic        req_taken = 1'b0;
    int unsigned burst_left   = 1;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned rx_mode      = 0;
    int unsigned rx_mode_left = 0;

    function automatic t_rsp_item receiver_step(input logic cmd, input logic [7:0] b);
        t_rsp_item   r;
        logic [16:0] tries;
        r        = '0;
        r.status = ST_RUN;
        tries    = {1'b0, cfg.retry_limit} + 17'd1;
        if (cmd == CMD_ARM) begin
            rx_phase    = WAIT_R1;
            attempts    = '0;
            payload_cnt = '0;
            r1_held     = '0;
        end else begin
            case (rx_phase)
                WAIT_R1: begin
                    attempts = attempts + 17'd1;
                    if (!b[7]) begin
                        r1_held  = b;
                        rx_phase = (cfg.data_length == 11'd0) ? WAIT_BUSY : WAIT_TOKEN;
                        attempts = '0;
                    end else if (attempts >= tries) begin
                        r.status   = ST_TIMEOUT;
                        r.done_res = 1'b1;
                    end
                end
                WAIT_TOKEN: begin
                    attempts = attempts + 17'd1;
                    if (b == START_TOKEN) begin
                        payload_cnt = '0;
                        if (cfg.data_length <= 11'd1) begin
                            rx_phase = WAIT_BUSY;
                            attempts = '0;
                        end else begin
                            rx_phase = WAIT_PAYLOAD;
                        end
                    end else if (b != IDLE_BYTE) begin
                        r.status   = ST_TOKEN;
                        r.done_res = 1'b1;
                    end else if (attempts >= tries) begin
                        r.status   = ST_TIMEOUT;
                        r.done_res = 1'b1;
                    end
                end
                WAIT_PAYLOAD: begin
                    r.data_byte  = b;
                    r.data_valid = 1'b1;
                    payload_cnt  = payload_cnt + 11'd1;
                    if (cfg.data_length <= 11'd1 || payload_cnt >= cfg.data_length - 11'd1) begin
                        rx_phase = WAIT_BUSY;
                        attempts = '0;
                    end
                end
                WAIT_BUSY: begin
                    attempts = attempts + 17'd1;
                    if (b == IDLE_BYTE) begin
                        r.status   = ST_OK;
                        r.done_res = 1'b1;
                    end else if (attempts >= {9'd0, cfg.busy_limit}) begin
                        r.status   = ST_BUSY;
                        r.done_res = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (r.done_res)
            rx_phase = WAIT_IDLE;
        r.r1_value = r1_held;
        return r;
    endfunction

    // result checking, item acceptance and watchdog
    always @(posedge i_clk) begin
        t_rsp_item got;
        t_rsp_item want;
        if (running) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.status     = rsp_if.status;
                got.r1_value   = rsp_if.r1_value;
                got.data_byte  = rsp_if.data_byte;
                got.data_valid = rsp_if.data_valid;
                got.done_res   = rsp_if.done_res;
                rsp_count++;
                status_seen[got.status]++;
                payload_seen += got.data_valid;
                if (rsp_due_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected result: st=%0d r1=%02h db=%02h dv=%0b dn=%0b",
                                 got.status, got.r1_value, got.data_byte, got.data_valid,
                                 got.done_res);
                end else begin
                    want = rsp_due_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("mismatch at result %0d: exp st=%0d r1=%02h db=%02h dv=%0b dn=%0b",
                                     rsp_count, want.status, want.r1_value, want.data_byte,
                                     want.data_valid, want.done_res);
                            $display("    got st=%0d r1=%02h db=%02h dv=%0b dn=%0b",
                                     got.status, got.r1_value, got.data_byte, got.data_valid,
                                     got.done_res);
                        end
                    end
                end
            end
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                rsp_due_q.push_back(receiver_step(req_if.cmd, req_if.rx_byte));
                item_count++;
            end
            if (req_taken || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // sender bursts and receiver stalls
    always @(negedge i_clk) begin
        t_spi_item itm;
        if (running) begin
            if (!(req_if.valid && !req_taken)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    itm = byte_q.pop_front();
                    req_if.valid   <= 1'b1;
                    req_if.cmd     <= itm.cmd;
                    req_if.rx_byte <= itm.rx_byte;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end

            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if ($urandom_range(0, 9) == 0) begin
                            stall_left   = $urandom_range(1, 12);
                            rsp_if.ready <= 1'b0;
                        end else begin
                            rsp_if.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    function automatic void push_item(input logic cmd, input logic [7:0] b);
        t_spi_item itm;
        itm.cmd     = cmd;
        itm.rx_byte = b;
        byte_q.push_back(itm);
        gen_count++;
    endfunction

    task automatic drain();
        while (byte_q.size() != 0 || req_if.valid || rsp_due_q.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_RETRY_LIMIT: cfg.retry_limit = val[15:0];
            REG_DATA_LENGTH: cfg.data_length = val[10:0];
            REG_BUSY_LIMIT:  cfg.busy_limit  = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_cfg(input int unsigned retry, input int unsigned len,
                             input int unsigned busy);
        drain();
        cfg_write(REG_RETRY_LIMIT, 32'(retry));
        cfg_write(REG_DATA_LENGTH, 32'(len));
        cfg_write(REG_BUSY_LIMIT, 32'(busy));
        phase_count++;
    endtask

    // one response sequence, mostly well formed
    task automatic gen_response();
        int unsigned lead;
        int unsigned beff;
        int unsigned lmax;
        beff = (cfg.busy_limit == 8'd0) ? 1 : cfg.busy_limit;
        if ($urandom_range(0, 11) == 0) begin
            // abandoned wait, re-armed below
            push_item(CMD_ARM, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        end
        push_item(CMD_ARM, 8'($urandom_range(0, 255)));
        if (cfg.retry_limit <= 16'd8 && $urandom_range(0, 5) == 0) begin
            repeat (cfg.retry_limit + 1) push_item(CMD_BYTE, 8'h80 | 8'($urandom_range(0, 127)));
            return;
        end
        lmax = (cfg.retry_limit < 16'd4) ? cfg.retry_limit : 4;
        lead = $urandom_range(0, lmax);
        repeat (lead) push_item(CMD_BYTE, 8'h80 | 8'($urandom_range(0, 127)));
        push_item(CMD_BYTE, 8'($urandom_range(0, 127)));
        if (cfg.data_length != 11'd0) begin
            case ($urandom_range(0, 9))
                0: begin
                    push_item(CMD_BYTE, 8'($urandom_range(0, 253)));
                    return;
                end
                1: begin
                    if (cfg.retry_limit <= 16'd8) begin
                        repeat (cfg.retry_limit + 1) push_item(CMD_BYTE, IDLE_BYTE);
                        return;
                    end
                end
                default: ;
            endcase
            lead = $urandom_range(0, lmax);
            repeat (lead) push_item(CMD_BYTE, IDLE_BYTE);
            push_item(CMD_BYTE, START_TOKEN);
            repeat (cfg.data_length - 1) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0) begin
            repeat (beff) push_item(CMD_BYTE, 8'($urandom_range(0, 254)));
        end else begin
            lead = $urandom_range(0, (beff - 1 < 5) ? beff - 1 : 5);
            repeat (lead) push_item(CMD_BYTE, 8'($urandom_range(0, 254)));
            push_item(CMD_BYTE, IDLE_BYTE);
        end
        if ($urandom_range(0, 9) == 0)
            push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned p;
        int unsigned start;
        req_if.valid   = 1'b0;
        req_if.cmd     = CMD_ARM;
        req_if.rx_byte = 8'h00;
        rsp_if.ready   = 1'b0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        cfg.retry_limit = RETRY_LIMIT_RESET;
        cfg.data_length = DATA_LENGTH_RESET;
        cfg.busy_limit  = BUSY_LIMIT_RESET;
        rx_phase    = WAIT_IDLE;
        attempts    = '0;
        payload_cnt = '0;
        r1_held     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;

        // reset limits: R1 only
        push_item(CMD_ARM, 8'h00);
        push_item(CMD_BYTE, IDLE_BYTE);
        push_item(CMD_BYTE, 8'h7F);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, IDLE_BYTE);
        push_item(CMD_BYTE, 8'h55);
        push_item(CMD_ARM, 8'hFF);
        push_item(CMD_BYTE, 8'h80);
        push_item(CMD_ARM, 8'hA5);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, IDLE_BYTE);

        // single try, one-byte response, tightest busy limit
        apply_cfg(0, 1, 1);
        push_item(CMD_ARM, 8'h00);
        push_item(CMD_BYTE, 8'h80);
        push_item(CMD_ARM, 8'h00);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, START_TOKEN);
        push_item(CMD_BYTE, IDLE_BYTE);
        push_item(CMD_ARM, 8'h00);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, 8'h12);
        push_item(CMD_ARM, 8'h00);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, IDLE_BYTE);

        // short payload, zero busy limit
        apply_cfg(1, 3, 0);
        push_item(CMD_ARM, 8'h00);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, IDLE_BYTE);
        push_item(CMD_BYTE, START_TOKEN);
        push_item(CMD_BYTE, 8'hAA);
        push_item(CMD_BYTE, 8'h55);
        push_item(CMD_BYTE, 8'h00);

        p = 0;
        while (gen_count < ITEM_TARGET) begin
            case (p)
                1: apply_cfg(65535, $urandom_range(0, 4), $urandom_range(1, 6));
                2: apply_cfg($urandom_range(0, 3), $urandom_range(100, 200),
                             $urandom_range(1, 4));
                3: apply_cfg($urandom_range(0, 4), 0, 255);
                default: apply_cfg(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000)
                                                              : $urandom_range(0, 6),
                                   ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12),
                                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255)
                                                              : $urandom_range(1, 8));
            endcase
            start = gen_count;
            while (gen_count - start < 60 && gen_count < ITEM_TARGET)
                gen_response();
            p++;
        end
        drain();

        $display("covered %0d items and %0d results over %0d register settings",
                 item_count, rsp_count, phase_count);
        $display("outcomes: %0d success, %0d timeout, %0d bad token, %0d busy, %0d payload bytes",
                 status_seen[ST_OK], status_seen[ST_TIMEOUT], status_seen[ST_TOKEN],
                 status_seen[ST_BUSY], payload_seen);
        if (err_count == 0 && rsp_due_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_ifs.sv
hw/rtl/ssr_regs.sv
hw/rtl/sd_spi_response_receiver.sv
tb/testbench.sv
